/* hw/rtl/atfp_pkg.sv */
// Shared types and constants for the ASCII triple frame parser.
// No dependencies; used by every module under hw/rtl.
package atfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 7;
    localparam int DIGIT_SLOTS = 12;
    localparam int GROUP_LEN   = 4;
    localparam int SLOT_W      = 4;
    localparam int VALUE_W     = 11;
    localparam int SUM_W       = 19;
    localparam int MAG_W       = 18;
    localparam int QUOT_W      = 8;
    localparam int REM_W       = 10;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h73;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h65;
    localparam logic [BYTE_W-1:0] ASCII_ZERO       = 8'h30;

    // floor(a / 1000) == (a * RECIP) >> RECIP_SHIFT for every a below 2**18
    localparam int                RECIP_SHIFT = 28;
    localparam int                RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP      = 19'd268436;
    localparam int                PROD_W      = MAG_W + RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 1'b0,
        CFG_END_MARKER   = 1'b1
    } cfg_reg_e;

    typedef logic [DIGIT_SLOTS-1:0][BYTE_W-1:0] digit_store_t;
    typedef logic [GROUP_LEN-1:0][BYTE_W-1:0]   digit_group_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_t;

    function automatic slot_t slot_of(input logic [POS_W-1:0] pos);
        slot_t s;
        s.hit = 1'b1;
        case (pos)
            7'd2:    s.idx = 4'd0;
            7'd3:    s.idx = 4'd1;
            7'd4:    s.idx = 4'd2;
            7'd5:    s.idx = 4'd3;
            7'd8:    s.idx = 4'd4;
            7'd9:    s.idx = 4'd5;
            7'd10:   s.idx = 4'd6;
            7'd11:   s.idx = 4'd7;
            7'd14:   s.idx = 4'd8;
            7'd15:   s.idx = 4'd9;
            7'd16:   s.idx = 4'd10;
            7'd17:   s.idx = 4'd11;
            default: begin
                s.hit = 1'b0;
                s.idx = 4'd0;
            end
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/ascii_triple_frame_parser_unit.sv */
// Top level of the ASCII triple frame parser: frame tracker plus three value lanes.
// Depends on atfp_pkg, atfp_frame and atfp_lane.
// A result passes through the stage valids v1, v2 and v3 after the end-marker byte transfer and is on m_valid from v3.
// Throughput: one byte per cycle while s_ready is high; the three-stage lane pipeline holds up to 3 results.
// s_ready drops only when all three lane stages hold results and m_ready is low.
// Reset (aresetn low, synchronous): markers return to 's'/'e', frame closed,
// position zero, digit store all '0', pipeline empty.
module ascii_triple_frame_parser_unit #(
    parameter int BUFFER_DEPTH = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [atfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atfp_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [atfp_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [atfp_pkg::VALUE_W-1:0] m_x_value,
    output logic signed [atfp_pkg::VALUE_W-1:0] m_y_value,
    output logic signed [atfp_pkg::VALUE_W-1:0] m_z_value
);

    logic                   accept;
    logic                   emit;
    atfp_pkg::digit_store_t store;
    atfp_pkg::pipe_ctrl_t   ctrl;
    logic                   v1_reg, v1_next;
    logic                   v2_reg, v2_next;
    logic                   v3_reg, v3_next;

    always_comb begin
        ctrl.ld3 = !v3_reg || m_ready;
        ctrl.ld2 = !v2_reg || ctrl.ld3;
        ctrl.ld1 = !v1_reg || ctrl.ld2;
        v1_next  = ctrl.ld1 ? (accept && emit) : v1_reg;
        v2_next  = ctrl.ld2 ? v1_reg : v2_reg;
        v3_next  = ctrl.ld3 ? v2_reg : v3_reg;
    end

    assign s_ready = ctrl.ld1;
    assign accept  = s_valid && s_ready;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    atfp_frame #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .emit      (emit),
        .store     (store)
    );

    atfp_lane u_lane_x (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .group (store[3:0]),
        .value (m_x_value)
    );

    atfp_lane u_lane_y (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .group (store[7:4]),
        .value (m_y_value)
    );

    atfp_lane u_lane_z (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .group (store[11:8]),
        .value (m_z_value)
    );

    a_emit_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> v1_reg)
        else $error("end-marker transfer lost before first stage");

    a_free_output_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !v3_reg) |=> v3_reg)
        else $error("result did not advance into empty output stage");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_x_value >= -11'sd999 && m_x_value <= 11'sd999
                  && m_y_value >= -11'sd999 && m_y_value <= 11'sd999
                  && m_z_value >= -11'sd999 && m_z_value <= 11'sd999))
        else $error("decoded value out of range");

endmodule

/* hw/rtl/atfp_frame.sv */
// Frame tracking, marker registers and digit store of the parser.
// Depends on atfp_pkg.
module atfp_frame #(
    parameter int BUFFER_DEPTH = 100
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [atfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [atfp_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                               accept,
    input  logic [atfp_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               emit,
    output atfp_pkg::digit_store_t             store
);

    localparam logic [atfp_pkg::POS_W-1:0] DEPTH = atfp_pkg::POS_W'(BUFFER_DEPTH);

    logic [atfp_pkg::BYTE_W-1:0] start_marker_reg, start_marker_next;
    logic [atfp_pkg::BYTE_W-1:0] end_marker_reg, end_marker_next;
    logic                        in_frame_reg, in_frame_next;
    logic [atfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    atfp_pkg::digit_store_t      store_reg, store_next;
    atfp_pkg::slot_t             slot;
    logic                        is_start;
    logic                        is_end;

    always_comb begin
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        if (cfg_we) begin
            unique case (atfp_pkg::cfg_reg_e'(cfg_index))
                atfp_pkg::CFG_START_MARKER: start_marker_next = cfg_wdata;
                atfp_pkg::CFG_END_MARKER:   end_marker_next   = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_start = (rx_byte == start_marker_reg);
    assign is_end   = !is_start && in_frame_reg && (rx_byte == end_marker_reg);
    assign slot     = atfp_pkg::slot_of(pos_reg);
    assign emit     = is_end;
    assign store    = store_reg;

    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        store_next    = store_reg;
        if (accept) begin
            if (is_start) begin
                in_frame_next = 1'b1;
                pos_next      = '0;
            end else if (is_end) begin
                in_frame_next = 1'b0;
                pos_next      = '0;
            end else if (pos_reg < DEPTH) begin
                if (slot.hit) begin
                    store_next[slot.idx] = rx_byte;
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= atfp_pkg::START_MARKER_RST;
            end_marker_reg   <= atfp_pkg::END_MARKER_RST;
            in_frame_reg     <= 1'b0;
            pos_reg          <= '0;
            store_reg        <= {atfp_pkg::DIGIT_SLOTS{atfp_pkg::ASCII_ZERO}};
        end else begin
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
            in_frame_reg     <= in_frame_next;
            pos_reg          <= pos_next;
            store_reg        <= store_next;
        end
    end

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= DEPTH)
        else $error("byte position past buffer depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_end) |=> (!in_frame_reg && pos_reg == '0))
        else $error("end marker did not close frame");

    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_start) |=> (in_frame_reg && pos_reg == '0))
        else $error("start marker did not open frame");

endmodule

/* hw/rtl/atfp_lane.sv */
// One value lane: weighted digit sum, reciprocal quotient, signed remainder.
// Three register stages advanced by a pipe_ctrl_t. Depends on atfp_pkg.
module atfp_lane (
    input  logic                                aclk,
    input  atfp_pkg::pipe_ctrl_t                ctrl,
    input  atfp_pkg::digit_group_t              group,
    output logic signed [atfp_pkg::VALUE_W-1:0] value
);

    logic signed [8:0]                   dig [atfp_pkg::GROUP_LEN];
    logic signed [atfp_pkg::SUM_W-1:0]   sum;
    logic signed [atfp_pkg::SUM_W-1:0]   sum_abs;
    logic [atfp_pkg::MAG_W-1:0]          mag1_reg, mag1_next;
    logic                                neg1_reg, neg1_next;
    logic [atfp_pkg::PROD_W-1:0]         prod;
    logic [atfp_pkg::MAG_W-1:0]          mag2_reg;
    logic                                neg2_reg;
    logic [atfp_pkg::QUOT_W-1:0]         quot2_reg, quot2_next;
    logic [atfp_pkg::MAG_W-1:0]          diff;
    logic [atfp_pkg::REM_W-1:0]          rem;
    logic signed [atfp_pkg::VALUE_W-1:0] value_reg, value_next;

    always_comb begin
        for (int k = 0; k < atfp_pkg::GROUP_LEN; k++) begin
            dig[k] = $signed({1'b0, group[k]}) - 9'sd48;
        end
        sum = atfp_pkg::SUM_W'(dig[0]) * 19'sd1000
            + atfp_pkg::SUM_W'(dig[1]) * 19'sd100
            + atfp_pkg::SUM_W'(dig[2]) * 19'sd10
            + atfp_pkg::SUM_W'(dig[3]);
        neg1_next = sum[atfp_pkg::SUM_W-1];
        sum_abs   = neg1_next ? -sum : sum;
        mag1_next = sum_abs[atfp_pkg::MAG_W-1:0];
    end

    assign prod       = atfp_pkg::PROD_W'(mag1_reg) * atfp_pkg::PROD_W'(atfp_pkg::RECIP);
    assign quot2_next = prod[atfp_pkg::RECIP_SHIFT +: atfp_pkg::QUOT_W];

    always_comb begin
        diff = mag2_reg - atfp_pkg::MAG_W'(quot2_reg) * 18'd1000;
        rem  = diff[atfp_pkg::REM_W-1:0];
        if (neg2_reg ^ (quot2_reg != '0)) begin
            value_next = atfp_pkg::VALUE_W'(0) - atfp_pkg::VALUE_W'(rem);
        end else begin
            value_next = atfp_pkg::VALUE_W'(rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
        end
        if (ctrl.ld2) begin
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            quot2_reg <= quot2_next;
        end
        if (ctrl.ld3) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
